### rtl/i2cmts_pkg.sv
// Package for the I2C master transaction sequencer.
// Holds phase, command, selector and error codes, register defaults and item/result types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package i2cmts_pkg;

	localparam int unsigned WAIT_W = 12;
	localparam logic [WAIT_W-1:0] WAIT_MAX = 12'd4095;

	localparam logic [7:0] SHORT_WAIT_RESET = 8'd255;
	localparam logic [WAIT_W-1:0] RECEIVE_WAIT_RESET = 12'd2550;

	localparam logic [1:0] CFG_SHORT_WAIT = 2'd0;
	localparam logic [1:0] CFG_RECEIVE_WAIT = 2'd1;

	localparam logic [1:0] FUNC_POLL = 2'd0;
	localparam logic [1:0] FUNC_READ = 2'd1;
	localparam logic [1:0] FUNC_WRITE = 2'd2;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_TIMEOUT = 2'd1;
	localparam logic [1:0] ERR_WCOL = 2'd2;
	localparam logic [1:0] ERR_BCOL = 2'd3;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_START   = 4'd1,
		PH_ADDR    = 4'd2,
		PH_ACK     = 4'd3,
		PH_RX      = 4'd4,
		PH_ACKCLK  = 4'd5,
		PH_TXREADY = 4'd6,
		PH_TXDONE  = 4'd7,
		PH_TXACK   = 4'd8,
		PH_STOP    = 4'd9
	} phase_t;

	typedef enum logic [2:0] {
		CMD_NONE   = 3'd0,
		CMD_START  = 3'd1,
		CMD_SEND   = 3'd2,
		CMD_RCEN   = 3'd3,
		CMD_ACKCLK = 3'd4,
		CMD_STOP   = 3'd5,
		CMD_CLEAR  = 3'd6
	} cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic [6:0] slave_address;
		logic [7:0] byte_count;
		logic [7:0] write_byte;
		logic       op_done;
		logic       slave_acked;
		logic       rx_full;
		logic [7:0] rx_byte;
		logic       write_collision;
		logic       bus_collision;
	} item_t;

	typedef struct packed {
		cmd_t       engine_cmd;
		logic [7:0] cmd_byte;
		logic       ack_bit;
		logic       write_taken;
		logic       read_valid;
		logic [7:0] read_byte;
		logic       done_res;
		logic [1:0] error_code;
		logic [7:0] bytes_done;
		logic       busy_res;
	} result_t;

	typedef struct packed {
		logic [7:0]        short_wait_limit;
		logic [WAIT_W-1:0] receive_wait_limit;
	} limits_t;

	// input stage status as seen by the sequencing core
	typedef struct packed {
		logic valid;
	} stage_ctl_t;

endpackage

`default_nettype wire

### rtl/i2cmts_in_reg.sv
// Input stage of the I2C master transaction sequencer: one registered request.
// Depends on i2cmts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cmts_in_reg (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire i2cmts_pkg::item_t   item,
	input  wire logic                advance,
	output i2cmts_pkg::stage_ctl_t   ctl,
	output i2cmts_pkg::item_t        item_s1
);

	logic valid_s1;
	logic load;

	// refill whenever the held request moves on or the stage is empty
	assign load = !valid_s1 || advance;
	assign in_stall = !load;
	assign ctl.valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			item_s1 <= item;
		end
	end

endmodule

`default_nettype wire

### rtl/i2cmts_core.sv
// Sequencing core: transaction state, one-step update logic and the result register.
// Depends on i2cmts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cmts_core (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire i2cmts_pkg::stage_ctl_t ctl,
	input  wire i2cmts_pkg::item_t      item_s1,
	input  wire i2cmts_pkg::limits_t    limits,
	input  wire logic                   out_stall,
	output logic                        advance,
	output logic                        out_valid,
	output i2cmts_pkg::result_t         result
);

	i2cmts_pkg::phase_t            phase_q, phase_d;
	logic                          is_read_q, is_read_d;
	logic [7:0]                    target_count_q, target_count_d;
	logic [7:0]                    byte_index_q, byte_index_d;
	logic [i2cmts_pkg::WAIT_W-1:0] wait_q, wait_d;
	logic [1:0]                    last_error_q, last_error_d;
	logic [6:0]                    target_address_q, target_address_d;

	logic                          out_valid_q;
	i2cmts_pkg::result_t           result_q, res_d;

	logic                          ok;
	logic [i2cmts_pkg::WAIT_W-1:0] limit;
	logic [i2cmts_pkg::WAIT_W-1:0] wait_inc;
	logic [7:0]                    idx_inc;
	logic                          is_begin;

	assign advance = ctl.valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign result = result_q;

	assign idx_inc = byte_index_q + 8'd1;
	assign wait_inc = (wait_q < i2cmts_pkg::WAIT_MAX) ?
		wait_q + {{(i2cmts_pkg::WAIT_W-1){1'b0}}, 1'b1} : wait_q;
	assign is_begin = (item_s1.func == i2cmts_pkg::FUNC_READ) ||
		(item_s1.func == i2cmts_pkg::FUNC_WRITE);

	always_comb begin
		phase_d = phase_q;
		is_read_d = is_read_q;
		target_count_d = target_count_q;
		byte_index_d = byte_index_q;
		wait_d = wait_q;
		last_error_d = last_error_q;
		target_address_d = target_address_q;
		res_d = '0;
		res_d.engine_cmd = i2cmts_pkg::CMD_NONE;
		ok = 1'b0;
		limit = {{(i2cmts_pkg::WAIT_W-8){1'b0}}, limits.short_wait_limit};

		case (phase_q)
			i2cmts_pkg::PH_START, i2cmts_pkg::PH_ADDR, i2cmts_pkg::PH_TXDONE,
			i2cmts_pkg::PH_ACKCLK, i2cmts_pkg::PH_STOP: begin
				ok = item_s1.op_done;
			end
			i2cmts_pkg::PH_ACK, i2cmts_pkg::PH_TXACK: begin
				ok = item_s1.slave_acked;
			end
			i2cmts_pkg::PH_RX: begin
				ok = item_s1.rx_full;
				limit = limits.receive_wait_limit;
			end
			i2cmts_pkg::PH_TXREADY: begin
				ok = !item_s1.rx_full;
			end
			default: begin
				ok = 1'b0;
			end
		endcase

		if (is_begin) begin
			// a begin while busy is dropped
			if (phase_q == i2cmts_pkg::PH_IDLE) begin
				is_read_d = (item_s1.func == i2cmts_pkg::FUNC_READ);
				target_address_d = item_s1.slave_address;
				target_count_d = item_s1.byte_count;
				byte_index_d = '0;
				last_error_d = i2cmts_pkg::ERR_NONE;
				wait_d = '0;
				if (item_s1.write_collision) begin
					res_d.engine_cmd = i2cmts_pkg::CMD_CLEAR;
					last_error_d = i2cmts_pkg::ERR_WCOL;
					res_d.done_res = 1'b1;
				end else if (item_s1.bus_collision) begin
					res_d.engine_cmd = i2cmts_pkg::CMD_CLEAR;
					last_error_d = i2cmts_pkg::ERR_BCOL;
					res_d.done_res = 1'b1;
				end else begin
					res_d.engine_cmd = i2cmts_pkg::CMD_START;
					phase_d = i2cmts_pkg::PH_START;
				end
			end
		end else if (phase_q != i2cmts_pkg::PH_IDLE) begin
			if (!ok) begin
				wait_d = wait_inc;
				if (wait_inc >= limit) begin
					last_error_d = i2cmts_pkg::ERR_TIMEOUT;
					phase_d = i2cmts_pkg::PH_IDLE;
					wait_d = '0;
					res_d.done_res = 1'b1;
				end
			end else begin
				wait_d = '0;
				case (phase_q)
					i2cmts_pkg::PH_START: begin
						res_d.engine_cmd = i2cmts_pkg::CMD_SEND;
						res_d.cmd_byte = {target_address_q, is_read_q};
						phase_d = i2cmts_pkg::PH_ADDR;
					end
					i2cmts_pkg::PH_ADDR: begin
						phase_d = i2cmts_pkg::PH_ACK;
					end
					i2cmts_pkg::PH_ACK: begin
						if (target_count_q == 8'd0) begin
							res_d.engine_cmd = i2cmts_pkg::CMD_STOP;
							phase_d = i2cmts_pkg::PH_STOP;
						end else if (is_read_q) begin
							res_d.engine_cmd = i2cmts_pkg::CMD_RCEN;
							phase_d = i2cmts_pkg::PH_RX;
						end else begin
							phase_d = i2cmts_pkg::PH_TXREADY;
						end
					end
					i2cmts_pkg::PH_RX: begin
						res_d.read_valid = 1'b1;
						res_d.read_byte = item_s1.rx_byte;
						res_d.engine_cmd = i2cmts_pkg::CMD_ACKCLK;
						// NACK the last byte
						res_d.ack_bit = (idx_inc == target_count_q);
						phase_d = i2cmts_pkg::PH_ACKCLK;
					end
					i2cmts_pkg::PH_ACKCLK: begin
						byte_index_d = idx_inc;
						if (idx_inc == target_count_q) begin
							res_d.engine_cmd = i2cmts_pkg::CMD_STOP;
							phase_d = i2cmts_pkg::PH_STOP;
						end else begin
							res_d.engine_cmd = i2cmts_pkg::CMD_RCEN;
							phase_d = i2cmts_pkg::PH_RX;
						end
					end
					i2cmts_pkg::PH_TXREADY: begin
						res_d.engine_cmd = i2cmts_pkg::CMD_SEND;
						res_d.cmd_byte = item_s1.write_byte;
						res_d.write_taken = 1'b1;
						phase_d = i2cmts_pkg::PH_TXDONE;
					end
					i2cmts_pkg::PH_TXDONE: begin
						phase_d = i2cmts_pkg::PH_TXACK;
					end
					i2cmts_pkg::PH_TXACK: begin
						byte_index_d = idx_inc;
						if (idx_inc == target_count_q) begin
							res_d.engine_cmd = i2cmts_pkg::CMD_STOP;
							phase_d = i2cmts_pkg::PH_STOP;
						end else begin
							phase_d = i2cmts_pkg::PH_TXREADY;
						end
					end
					default: begin
						phase_d = i2cmts_pkg::PH_IDLE;
						res_d.done_res = 1'b1;
					end
				endcase
			end
		end

		res_d.error_code = last_error_d;
		res_d.bytes_done = byte_index_d;
		res_d.busy_res = (phase_d != i2cmts_pkg::PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= i2cmts_pkg::PH_IDLE;
			is_read_q <= 1'b0;
			target_count_q <= '0;
			byte_index_q <= '0;
			wait_q <= '0;
			last_error_q <= i2cmts_pkg::ERR_NONE;
			target_address_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q <= phase_d;
				is_read_q <= is_read_d;
				target_count_q <= target_count_d;
				byte_index_q <= byte_index_d;
				wait_q <= wait_d;
				last_error_q <= last_error_d;
				target_address_q <= target_address_d;
			end
			if (!out_valid_q || !out_stall) begin
				out_valid_q <= advance;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res_d;
		end
	end

endmodule

`default_nettype wire

### rtl/i2c_master_transaction_sequencer.sv
// I2C master transaction sequencer: sequences one 7-bit read or write transaction
// above a byte-level bus engine, one request in and one result out per step.
//
// Request channel (in_valid / in_stall): a begin read, begin write or a poll that
// carries the engine status. A request is taken when in_valid is high and in_stall
// low. Result channel (out_valid / out_stall): one result per request, in order,
// telling the engine what to do next and reporting progress and errors.
// Config channel (cfg_valid / cfg_ready, always ready): index 0 sets the short wait
// limit, index 1 the receive wait limit; other indexes are ignored. Write only idle.
//
// A request passes the input register, then the state update and the result register.
// Throughput is one request per cycle while out_stall is low; in_stall rises only
// when the result register is full and out_stall holds it; the held result and the
// held request then stay put. Reset returns the sequencer to idle with both limits
// at their defaults (255 and 2550 polls) and clears the error and byte counts.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_transaction_sequencer (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [11:0] cfg_data,

	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  func,
	input  wire logic [6:0]  slave_address,
	input  wire logic [7:0]  byte_count,
	input  wire logic [7:0]  write_byte,
	input  wire logic        op_done,
	input  wire logic        slave_acked,
	input  wire logic        rx_full,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        write_collision,
	input  wire logic        bus_collision,

	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       engine_cmd,
	output logic [7:0]       cmd_byte,
	output logic             ack_bit,
	output logic             write_taken,
	output logic             read_valid,
	output logic [7:0]       read_byte,
	output logic             done_res,
	output logic [1:0]       error_code,
	output logic [7:0]       bytes_done,
	output logic             busy_res
);

	i2cmts_pkg::item_t      item;
	i2cmts_pkg::item_t      item_s1;
	i2cmts_pkg::stage_ctl_t ctl;
	i2cmts_pkg::result_t    result;
	i2cmts_pkg::limits_t    limits_q;
	logic                   advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.short_wait_limit <= i2cmts_pkg::SHORT_WAIT_RESET;
			limits_q.receive_wait_limit <= i2cmts_pkg::RECEIVE_WAIT_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == i2cmts_pkg::CFG_SHORT_WAIT) begin
				limits_q.short_wait_limit <= cfg_data[7:0];
			end else if (cfg_index == i2cmts_pkg::CFG_RECEIVE_WAIT) begin
				limits_q.receive_wait_limit <= cfg_data;
			end
		end
	end

	assign item.func = func;
	assign item.slave_address = slave_address;
	assign item.byte_count = byte_count;
	assign item.write_byte = write_byte;
	assign item.op_done = op_done;
	assign item.slave_acked = slave_acked;
	assign item.rx_full = rx_full;
	assign item.rx_byte = rx_byte;
	assign item.write_collision = write_collision;
	assign item.bus_collision = bus_collision;

	i2cmts_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.item     (item),
		.advance  (advance),
		.ctl      (ctl),
		.item_s1  (item_s1)
	);

	i2cmts_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.item_s1   (item_s1),
		.limits    (limits_q),
		.out_stall (out_stall),
		.advance   (advance),
		.out_valid (out_valid),
		.result    (result)
	);

	assign engine_cmd = result.engine_cmd;
	assign cmd_byte = result.cmd_byte;
	assign ack_bit = result.ack_bit;
	assign write_taken = result.write_taken;
	assign read_valid = result.read_valid;
	assign read_byte = result.read_byte;
	assign done_res = result.done_res;
	assign error_code = result.error_code;
	assign bytes_done = result.bytes_done;
	assign busy_res = result.busy_res;

endmodule

`default_nettype wire
